// File: rtl/bus_transaction_stats_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Bus transaction statistics table: assertion macros
// Concurrent assertion wrappers on clk with rst as the disable condition.
// ----------------------------------------------------------------------------
`ifndef BUS_TRANSACTION_STATS_TABLE_UNIT_MACROS_SVH
`define BUS_TRANSACTION_STATS_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bus transaction stats table assertion failed");
`define BTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bus transaction stats table assertion failed");
`else
`define BTS_ASSERT_NOW(label, ante, cons)
`define BTS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// Bus transaction statistics table: package
// Field widths, table geometry, entry types, status codes and states.
// ----------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

  localparam int BUS_COUNT  = 7;
  localparam int PASS_SLOTS = 10;
  localparam int FAIL_SLOTS = 100;

  localparam int BUS_W      = 4;
  localparam int ADDR_W     = 10;
  localparam int CODE_W     = 13;
  localparam int COUNT_W    = 32;
  localparam int STATUS_W   = 4;
  localparam int SLOT_IDX_W = 7;

  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_MONITOR_ENABLE = '0;

  localparam int PASS_DEPTH = BUS_COUNT * PASS_SLOTS;
  localparam int FAIL_DEPTH = BUS_COUNT * FAIL_SLOTS;
  localparam int PASS_AW    = (PASS_DEPTH > 1) ? $clog2(PASS_DEPTH) : 1;
  localparam int FAIL_AW    = (FAIL_DEPTH > 1) ? $clog2(FAIL_DEPTH) : 1;
  localparam int PASS_SW    = $clog2(PASS_SLOTS + 1);
  localparam int FAIL_SW    = $clog2(FAIL_SLOTS + 1);
  localparam int SLOT_W     = (PASS_SW > FAIL_SW) ? PASS_SW : FAIL_SW;
  localparam int BUS_IDX_W  = (BUS_COUNT > 1) ? $clog2(BUS_COUNT) : 1;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } pass_entry_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CODE_W-1:0]  code;
    logic [COUNT_W-1:0] count;
  } fail_entry_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DISABLED     = 4'd0,
    STATUS_BAD_BUS      = 4'd1,
    STATUS_BAD_ADDR     = 4'd2,
    STATUS_PASS_NEW     = 4'd3,
    STATUS_PASS_COUNTED = 4'd4,
    STATUS_PASS_FULL    = 4'd5,
    STATUS_FAIL_NEW     = 4'd6,
    STATUS_FAIL_COUNTED = 4'd7,
    STATUS_FAIL_FULL    = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bts_in_if.sv
// ----------------------------------------------------------------------------
// Bus transaction statistics table: transaction channel
// Valid/ready channel carrying one completed bus transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bts_in_if;
  logic                              valid;
  logic                              ready;
  logic        [bts_pkg::BUS_W-1:0]  bus_number;
  logic        [bts_pkg::ADDR_W-1:0] target_address;
  logic                              has_messages;
  logic signed [bts_pkg::CODE_W-1:0] result_code;

  modport source (
    output valid, bus_number, target_address, has_messages, result_code,
    input  ready
  );

  modport sink (
    input  valid, bus_number, target_address, has_messages, result_code,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/bts_out_if.sv
// ----------------------------------------------------------------------------
// Bus transaction statistics table: result channel
// Valid/ready channel carrying the outcome of one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface bts_out_if;
  logic                                valid;
  logic                                ready;
  logic [bts_pkg::STATUS_W-1:0]        status;
  logic [bts_pkg::SLOT_IDX_W-1:0]      slot_index;
  logic [bts_pkg::COUNT_W-1:0]         slot_count;
  logic                                failure_warning;

  modport source (
    output valid, status, slot_index, slot_count, failure_warning,
    input  ready
  );

  modport sink (
    input  valid, status, slot_index, slot_count, failure_warning,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/bus_transaction_stats_table_unit.sv
// ----------------------------------------------------------------------------
// Bus transaction statistics table unit
// Counts passing transactions per bus and address and failing ones per bus,
// address and code, in two tables held in synchronous memories.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Transfer
//   txn       in          one completed bus transaction
//   stat      out         status, slot, count and warning for it
//   APB       in/out      monitor_enable register at byte address 0
//
// A rejected or disabled transaction passes from transfer in through the
// done state to the output register. A counted one walks its bus's table one
// slot per cycle through the memory read port, over the slots filled so far.
// Per-bus fill counters mark the used slots, so reset clears the tables at
// once and needs no clearing pass. The input is not ready during reset.
// A new transaction is taken while the previous result still waits in the
// output register; a finished walk then holds its result, and the input
// stays stalled, until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bus_transaction_stats_table_unit_macros.svh"

module bus_transaction_stats_table_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  bts_in_if.sink                            txn,
  bts_out_if.source                         stat,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bts_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [bts_pkg::CFG_DW-1:0]   pwdata,
  output logic      [bts_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready
);

  bts_pkg::state_t state;
  bts_pkg::state_t state_next;

  logic monitor_enable;

  logic [bts_pkg::SLOT_W-1:0] pass_fill [bts_pkg::BUS_COUNT];
  logic [bts_pkg::SLOT_W-1:0] fail_fill [bts_pkg::BUS_COUNT];

  bts_pkg::pass_entry_t pass_mem [bts_pkg::PASS_DEPTH];
  bts_pkg::fail_entry_t fail_mem [bts_pkg::FAIL_DEPTH];
  bts_pkg::pass_entry_t pass_rdata;
  bts_pkg::fail_entry_t fail_rdata;

  logic                                  cur_is_pass;
  logic        [bts_pkg::ADDR_W-1:0]     cur_addr;
  logic        [bts_pkg::CODE_W-1:0]     cur_code;
  logic        [bts_pkg::BUS_IDX_W-1:0]  bus_idx;
  logic        [bts_pkg::SLOT_W-1:0]     fill_limit;
  logic        [bts_pkg::SLOT_W-1:0]     rd_slot;
  logic        [bts_pkg::SLOT_W-1:0]     cmp_slot;
  logic                                  cmp_valid;

  logic [bts_pkg::STATUS_W-1:0]   res_status;
  logic [bts_pkg::SLOT_IDX_W-1:0] res_slot;
  logic [bts_pkg::COUNT_W-1:0]    res_count;
  logic                           res_warn;

  logic                           out_valid;
  logic [bts_pkg::STATUS_W-1:0]   out_status;
  logic [bts_pkg::SLOT_IDX_W-1:0] out_slot;
  logic [bts_pkg::COUNT_W-1:0]    out_count;
  logic                           out_warn;

  // Classification of the transaction at the input.
  logic                               accept;
  logic                               in_bus_ok;
  logic [bts_pkg::ADDR_W-1:0]         in_addr;
  logic                               in_is_pass;
  logic [bts_pkg::BUS_IDX_W-1:0]      in_bus_idx;
  logic                               in_counted;

  // Walk control.
  logic                               issue;
  logic                               hit;
  logic                               miss_done;
  logic                               room;
  logic                               finish;
  logic                               out_free;
  logic [bts_pkg::COUNT_W-1:0]        old_count;
  logic [bts_pkg::COUNT_W-1:0]        inc_count;
  logic [bts_pkg::SLOT_W-1:0]         table_slots;
  logic [bts_pkg::SLOT_W-1:0]         fill_of_cur;
  logic [bts_pkg::SLOT_W-1:0]         wr_slot;
  logic [bts_pkg::PASS_AW-1:0]        pass_base;
  logic [bts_pkg::FAIL_AW-1:0]        fail_base;
  logic [bts_pkg::PASS_AW-1:0]        pass_raddr;
  logic [bts_pkg::FAIL_AW-1:0]        fail_raddr;
  logic [bts_pkg::PASS_AW-1:0]        pass_waddr;
  logic [bts_pkg::FAIL_AW-1:0]        fail_waddr;
  logic                               pass_re;
  logic                               fail_re;
  logic                               pass_we;
  logic                               fail_we;
  logic                               new_write;
  bts_pkg::pass_entry_t               pass_wdata;
  bts_pkg::fail_entry_t               fail_wdata;

  logic                               res_load;
  logic [bts_pkg::STATUS_W-1:0]       res_status_next;
  logic [bts_pkg::SLOT_IDX_W-1:0]     res_slot_next;
  logic [bts_pkg::COUNT_W-1:0]        res_count_next;
  logic                               res_warn_next;

  logic                               cfg_write;
  logic [bts_pkg::REG_IDX_W-1:0]      cfg_index;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_index = paddr[bts_pkg::CFG_AW-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (cfg_index == bts_pkg::REG_MONITOR_ENABLE) ?
                     bts_pkg::CFG_DW'(monitor_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable <= 1'b0;
    end else if (cfg_write && (cfg_index == bts_pkg::REG_MONITOR_ENABLE)) begin
      monitor_enable <= pwdata[0];
    end
  end

  // Input side.
  assign txn.ready  = (state == bts_pkg::S_IDLE) && !rst;
  assign accept     = txn.valid && txn.ready;
  assign in_bus_ok  = (txn.bus_number != '0) &&
                      (txn.bus_number <= bts_pkg::BUS_W'(bts_pkg::BUS_COUNT));
  assign in_addr    = txn.has_messages ? txn.target_address : '0;
  assign in_is_pass = (txn.result_code != '0) && !txn.result_code[bts_pkg::CODE_W-1];
  assign in_bus_idx = bts_pkg::BUS_IDX_W'(txn.bus_number - 4'd1);
  assign in_counted = monitor_enable && in_bus_ok && (in_addr != '0);

  // Walk over the bus's table.
  assign out_free    = !out_valid || stat.ready;
  assign issue       = (rd_slot != fill_limit);
  assign hit         = cmp_valid && (cur_is_pass ?
                       (pass_rdata.addr == cur_addr) :
                       ((fail_rdata.addr == cur_addr) && (fail_rdata.code == cur_code)));
  assign miss_done   = !cmp_valid && !issue;
  assign table_slots = cur_is_pass ? bts_pkg::SLOT_W'(bts_pkg::PASS_SLOTS) :
                                     bts_pkg::SLOT_W'(bts_pkg::FAIL_SLOTS);
  assign room        = (fill_limit != table_slots);
  assign finish      = hit || miss_done;
  assign fill_of_cur = cur_is_pass ? pass_fill[bus_idx] : fail_fill[bus_idx];
  assign old_count   = cur_is_pass ? pass_rdata.count : fail_rdata.count;
  assign inc_count   = (old_count == '1) ? old_count : old_count + 1'b1;
  assign wr_slot     = hit ? cmp_slot : fill_limit;

  assign pass_base  = bts_pkg::PASS_AW'(bus_idx * bts_pkg::PASS_SLOTS);
  assign fail_base  = bts_pkg::FAIL_AW'(bus_idx * bts_pkg::FAIL_SLOTS);
  assign pass_raddr = pass_base + bts_pkg::PASS_AW'(rd_slot);
  assign fail_raddr = fail_base + bts_pkg::FAIL_AW'(rd_slot);
  assign pass_waddr = pass_base + bts_pkg::PASS_AW'(wr_slot);
  assign fail_waddr = fail_base + bts_pkg::FAIL_AW'(wr_slot);

  always_comb begin
    state_next = state;
    case (state)
      bts_pkg::S_IDLE: begin
        if (accept) begin
          state_next = in_counted ? bts_pkg::S_SCAN : bts_pkg::S_DONE;
        end
      end
      bts_pkg::S_SCAN: begin
        if (finish) begin
          state_next = bts_pkg::S_DONE;
        end
      end
      bts_pkg::S_DONE: begin
        if (out_free) begin
          state_next = bts_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bts_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_load        = 1'b0;
    res_status_next = bts_pkg::STATUS_DISABLED;
    res_slot_next   = '0;
    res_count_next  = '0;
    res_warn_next   = 1'b0;
    pass_re         = 1'b0;
    fail_re         = 1'b0;
    pass_we         = 1'b0;
    fail_we         = 1'b0;
    new_write       = 1'b0;
    pass_wdata      = '{addr: cur_addr, count: (hit ? inc_count : bts_pkg::COUNT_W'(1))};
    fail_wdata      = '{addr: cur_addr, code: cur_code,
                        count: (hit ? inc_count : bts_pkg::COUNT_W'(1))};
    case (state)
      bts_pkg::S_IDLE: begin
        if (accept && !in_counted) begin
          res_load = 1'b1;
          if (!monitor_enable) begin
            res_status_next = bts_pkg::STATUS_DISABLED;
          end else if (!in_bus_ok) begin
            res_status_next = bts_pkg::STATUS_BAD_BUS;
          end else begin
            res_status_next = bts_pkg::STATUS_BAD_ADDR;
          end
        end
      end
      bts_pkg::S_SCAN: begin
        pass_re = issue && cur_is_pass;
        fail_re = issue && !cur_is_pass;
        if (finish) begin
          res_load      = 1'b1;
          res_warn_next = !cur_is_pass;
          if (hit) begin
            res_status_next = cur_is_pass ? bts_pkg::STATUS_PASS_COUNTED :
                                            bts_pkg::STATUS_FAIL_COUNTED;
            res_slot_next   = bts_pkg::SLOT_IDX_W'(cmp_slot);
            res_count_next  = inc_count;
            pass_we         = cur_is_pass;
            fail_we         = !cur_is_pass;
          end else if (room) begin
            res_status_next = cur_is_pass ? bts_pkg::STATUS_PASS_NEW :
                                            bts_pkg::STATUS_FAIL_NEW;
            res_slot_next   = bts_pkg::SLOT_IDX_W'(fill_limit);
            res_count_next  = bts_pkg::COUNT_W'(1);
            pass_we         = cur_is_pass;
            fail_we         = !cur_is_pass;
            new_write       = 1'b1;
          end else begin
            res_status_next = cur_is_pass ? bts_pkg::STATUS_PASS_FULL :
                                            bts_pkg::STATUS_FAIL_FULL;
          end
        end
      end
      bts_pkg::S_DONE: begin
        res_load = 1'b0;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bts_pkg::S_IDLE;
      rd_slot   <= '0;
      cmp_valid <= 1'b0;
      for (int b = 0; b < bts_pkg::BUS_COUNT; b++) begin
        pass_fill[b] <= '0;
        fail_fill[b] <= '0;
      end
    end else begin
      state     <= state_next;
      cmp_valid <= (state == bts_pkg::S_SCAN) && issue && !finish;
      if (accept) begin
        rd_slot <= '0;
      end else if ((state == bts_pkg::S_SCAN) && issue) begin
        rd_slot <= rd_slot + 1'b1;
      end
      if (new_write) begin
        if (cur_is_pass) begin
          pass_fill[bus_idx] <= fill_limit + 1'b1;
        end else begin
          fail_fill[bus_idx] <= fill_limit + 1'b1;
        end
      end
    end
  end

  // Item and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_is_pass <= in_is_pass;
      cur_addr    <= in_addr;
      cur_code    <= txn.result_code;
      bus_idx     <= in_bus_idx;
      if (in_counted) begin
        fill_limit <= in_is_pass ? pass_fill[in_bus_idx] : fail_fill[in_bus_idx];
      end
    end
    if ((state == bts_pkg::S_SCAN) && issue) begin
      cmp_slot <= rd_slot;
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_count  <= res_count_next;
      res_warn   <= res_warn_next;
    end
  end

  // Table memories.
  always_ff @(posedge clk) begin
    if (pass_we) begin
      pass_mem[pass_waddr] <= pass_wdata;
    end
    if (pass_re) begin
      pass_rdata <= pass_mem[pass_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fail_we) begin
      fail_mem[fail_waddr] <= fail_wdata;
    end
    if (fail_re) begin
      fail_rdata <= fail_mem[fail_raddr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == bts_pkg::S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (stat.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == bts_pkg::S_DONE) && out_free) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_count  <= res_count;
      out_warn   <= res_warn;
    end
  end

  assign stat.valid           = out_valid;
  assign stat.status          = out_status;
  assign stat.slot_index      = out_slot;
  assign stat.slot_count      = out_count;
  assign stat.failure_warning = out_warn;

  `BTS_ASSERT_NOW(a_read_in_fill, (state == bts_pkg::S_SCAN) && issue, rd_slot < fill_limit)
  `BTS_ASSERT_NOW(a_one_table_written, 1'b1, !(pass_we && fail_we))
  `BTS_ASSERT_NEXT(a_fill_grows, new_write, fill_of_cur == $past(fill_limit) + 1'b1)
  `BTS_ASSERT_NEXT(a_done_to_out, (state == bts_pkg::S_DONE) && out_free, out_valid && txn.ready)

endmodule

`default_nettype wire

// File: sim/tb_bus_transaction_stats_table_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the bus transaction statistics table unit
// A queue-fed driver offers bus transactions with random gaps. A clocked
// monitor stalls the result channel at random and holds it off once for a
// long stretch. Each transfer is checked field by field against a
// transaction-level model of the pass and failure tables. The enable
// register is rewritten over APB between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_bus_transaction_stats_table_unit;

  localparam logic [bts_pkg::REG_IDX_W-1:0] REG_SPARE = 1'b1;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 800;

  typedef struct {
    logic [bts_pkg::BUS_W-1:0]  bus;
    logic [bts_pkg::ADDR_W-1:0] addr;
    logic                       has;
    logic [bts_pkg::CODE_W-1:0] code;
  } txn_t;

  typedef struct {
    bts_pkg::status_t                status;
    logic [bts_pkg::SLOT_IDX_W-1:0]  slot;
    logic [bts_pkg::COUNT_W-1:0]     count;
    logic                            warn;
  } outcome_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [bts_pkg::CFG_AW-1:0] paddr;
  logic [bts_pkg::CFG_DW-1:0] pwdata;
  logic [bts_pkg::CFG_DW-1:0] prdata;
  logic                       pready;

  bts_in_if  txn_if ();
  bts_out_if stat_if ();

  bus_transaction_stats_table_unit dut (
    .clk     (clk),
    .rst     (rst),
    .txn     (txn_if),
    .stat    (stat_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic                        monitor_on = 1'b0;
  logic [bts_pkg::ADDR_W-1:0]  pass_addr [bts_pkg::BUS_COUNT][bts_pkg::PASS_SLOTS];
  logic [bts_pkg::COUNT_W-1:0] pass_cnt  [bts_pkg::BUS_COUNT][bts_pkg::PASS_SLOTS];
  logic [bts_pkg::ADDR_W-1:0]  fail_addr [bts_pkg::BUS_COUNT][bts_pkg::FAIL_SLOTS];
  logic [bts_pkg::CODE_W-1:0]  fail_code [bts_pkg::BUS_COUNT][bts_pkg::FAIL_SLOTS];
  logic [bts_pkg::COUNT_W-1:0] fail_cnt  [bts_pkg::BUS_COUNT][bts_pkg::FAIL_SLOTS];

  txn_t     queued_txns[$];
  outcome_t pending_outcomes[$];

  int txns_queued   = 0;
  int txns_accepted = 0;
  int outcomes_seen = 0;
  int mismatches    = 0;
  int src_max_gap   = 12;
  int sink_max_gap  = 12;
  int src_wait      = 0;
  int sink_wait     = 0;
  int hold_left     = 0;

  logic [bts_pkg::ADDR_W-1:0] addr_pool [16];
  logic [bts_pkg::CODE_W-1:0] pass_pool [8];
  logic [bts_pkg::CODE_W-1:0] fail_pool [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic outcome_t count_transfer(input txn_t t);
    outcome_t                   r;
    logic [bts_pkg::ADDR_W-1:0] a;
    int                         b;
    r.status = bts_pkg::STATUS_DISABLED;
    r.slot   = '0;
    r.count  = '0;
    r.warn   = 1'b0;
    a = t.has ? t.addr : '0;
    b = int'(t.bus) - 1;
    if (!monitor_on) return r;
    if (t.bus == 0 || t.bus > bts_pkg::BUS_COUNT) begin
      r.status = bts_pkg::STATUS_BAD_BUS;
      return r;
    end
    if (a == '0) begin
      r.status = bts_pkg::STATUS_BAD_ADDR;
      return r;
    end
    if (t.code != '0 && !t.code[bts_pkg::CODE_W-1]) begin
      r.status = bts_pkg::STATUS_PASS_FULL;
      for (int i = 0; i < bts_pkg::PASS_SLOTS; i++) begin
        if (pass_addr[b][i] == '0) begin
          pass_addr[b][i] = a;
          pass_cnt[b][i]  = 1;
          r.status = bts_pkg::STATUS_PASS_NEW;
          r.slot   = bts_pkg::SLOT_IDX_W'(i);
          r.count  = pass_cnt[b][i];
          return r;
        end
        if (pass_addr[b][i] == a) begin
          if (pass_cnt[b][i] != '1) pass_cnt[b][i] = pass_cnt[b][i] + 1;
          r.status = bts_pkg::STATUS_PASS_COUNTED;
          r.slot   = bts_pkg::SLOT_IDX_W'(i);
          r.count  = pass_cnt[b][i];
          return r;
        end
      end
      return r;
    end
    r.status = bts_pkg::STATUS_FAIL_FULL;
    r.warn   = 1'b1;
    for (int i = 0; i < bts_pkg::FAIL_SLOTS; i++) begin
      if (fail_addr[b][i] == '0) begin
        fail_addr[b][i] = a;
        fail_code[b][i] = t.code;
        fail_cnt[b][i]  = 1;
        r.status = bts_pkg::STATUS_FAIL_NEW;
        r.slot   = bts_pkg::SLOT_IDX_W'(i);
        r.count  = fail_cnt[b][i];
        return r;
      end
      if (fail_addr[b][i] == a && fail_code[b][i] == t.code) begin
        if (fail_cnt[b][i] != '1) fail_cnt[b][i] = fail_cnt[b][i] + 1;
        r.status = bts_pkg::STATUS_FAIL_COUNTED;
        r.slot   = bts_pkg::SLOT_IDX_W'(i);
        r.count  = fail_cnt[b][i];
        return r;
      end
    end
    return r;
  endfunction

  task automatic offer(input txn_t t);
    queued_txns.push_back(t);
    txns_queued++;
  endtask

  task automatic offer_fields(input logic [bts_pkg::BUS_W-1:0] b,
                              input logic [bts_pkg::ADDR_W-1:0] a,
                              input logic h, input logic [bts_pkg::CODE_W-1:0] c);
    txn_t t;
    t.bus  = b;
    t.addr = a;
    t.has  = h;
    t.code = c;
    offer(t);
  endtask

  task automatic offer_random(input int n, input int noise_pct);
    txn_t t;
    repeat (n) begin
      if ($urandom_range(99, 0) < noise_pct) begin
        t.bus  = bts_pkg::BUS_W'($urandom);
        t.addr = bts_pkg::ADDR_W'($urandom);
        t.has  = 1'($urandom);
        t.code = bts_pkg::CODE_W'($urandom);
      end else begin
        t.bus  = bts_pkg::BUS_W'($urandom_range(bts_pkg::BUS_COUNT, 1));
        t.addr = addr_pool[$urandom_range(15, 0)];
        t.has  = 1'b1;
        if ($urandom_range(1, 0) == 1) t.code = pass_pool[$urandom_range(7, 0)];
        else t.code = fail_pool[$urandom_range(7, 0)];
      end
      offer(t);
    end
  endtask

  task automatic draw_pools();
    foreach (addr_pool[i]) addr_pool[i] = bts_pkg::ADDR_W'($urandom_range(1023, 1));
    foreach (pass_pool[i]) pass_pool[i] = bts_pkg::CODE_W'($urandom_range(4095, 1));
    foreach (fail_pool[i]) fail_pool[i] = bts_pkg::CODE_W'(0 - $urandom_range(4096, 0));
    addr_pool[0] = bts_pkg::ADDR_W'(1);
    addr_pool[1] = bts_pkg::ADDR_W'(1023);
    pass_pool[0] = bts_pkg::CODE_W'(4095);
    fail_pool[0] = '0;
    fail_pool[1] = bts_pkg::CODE_W'(13'h1000);
  endtask

  task automatic drain();
    while (txns_accepted != txns_queued || pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [bts_pkg::REG_IDX_W-1:0] idx,
                           input logic [bts_pkg::CFG_DW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == bts_pkg::REG_MONITOR_ENABLE) monitor_on = value[0];
  endtask

  always @(posedge clk) begin : drive_txn
    txn_t sent;
    txn_t next_txn;
    if (rst) begin
      txn_if.valid <= 1'b0;
      src_wait = 0;
    end else if (!txn_if.valid || txn_if.ready) begin
      if (txn_if.valid) begin
        sent.bus  = txn_if.bus_number;
        sent.addr = txn_if.target_address;
        sent.has  = txn_if.has_messages;
        sent.code = txn_if.result_code;
        pending_outcomes.push_back(count_transfer(sent));
        txns_accepted++;
      end
      if (src_wait > 0) begin
        src_wait--;
        txn_if.valid <= 1'b0;
      end else if (queued_txns.size() != 0) begin
        next_txn = queued_txns.pop_front();
        txn_if.bus_number     <= next_txn.bus;
        txn_if.target_address <= next_txn.addr;
        txn_if.has_messages   <= next_txn.has;
        txn_if.result_code    <= next_txn.code;
        txn_if.valid          <= 1'b1;
        src_wait = $urandom_range(src_max_gap, 0);
      end else begin
        txn_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_stat
    outcome_t want;
    if (rst) begin
      stat_if.ready <= 1'b0;
      sink_wait = 0;
      hold_left = 0;
    end else begin
      if (stat_if.valid && stat_if.ready) begin
        outcomes_seen++;
        if (pending_outcomes.size() == 0) begin
          $error("result transfer with no transaction outstanding");
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (stat_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, stat_if.status);
            mismatches++;
          end
          if (stat_if.slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, stat_if.slot_index);
            mismatches++;
          end
          if (stat_if.slot_count !== want.count) begin
            $error("slot_count: expected %0d, got %0d", want.count, stat_if.slot_count);
            mismatches++;
          end
          if (stat_if.failure_warning !== want.warn) begin
            $error("failure_warning: expected %0d, got %0d", want.warn,
                   stat_if.failure_warning);
            mismatches++;
          end
        end
        sink_wait = $urandom_range(sink_max_gap, 0);
        if (outcomes_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stat_if.ready <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        stat_if.ready <= 1'b0;
      end else begin
        stat_if.ready <= 1'b1;
      end
    end
  end

  initial begin : run_test
    rst     = 1'b1;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    txn_if.valid          = 1'b0;
    txn_if.bus_number     = '0;
    txn_if.target_address = '0;
    txn_if.has_messages   = 1'b0;
    txn_if.result_code    = '0;
    stat_if.ready         = 1'b0;
    for (int b = 0; b < bts_pkg::BUS_COUNT; b++) begin
      for (int i = 0; i < bts_pkg::PASS_SLOTS; i++) begin
        pass_addr[b][i] = '0;
        pass_cnt[b][i]  = '0;
      end
      for (int i = 0; i < bts_pkg::FAIL_SLOTS; i++) begin
        fail_addr[b][i] = '0;
        fail_code[b][i] = '0;
        fail_cnt[b][i]  = '0;
      end
    end
    draw_pools();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // The monitor starts disabled, so every transfer is ignored.
    offer_random(6, 50);
    drain();

    cfg_write(bts_pkg::REG_MONITOR_ENABLE, 32'h0000_0001);
    offer_fields(4'd0, 10'd5, 1'b1, 13'd1);
    offer_fields(bts_pkg::BUS_W'(bts_pkg::BUS_COUNT + 1), 10'd5, 1'b1, 13'd1);
    offer_fields(4'd15, 10'd0, 1'b0, 13'd0);
    offer_fields(4'd1, 10'd0, 1'b1, 13'd1);
    offer_fields(4'd1, 10'd1023, 1'b0, bts_pkg::CODE_W'(-1));
    offer_fields(4'd1, 10'd1023, 1'b1, 13'd4095);
    offer_fields(4'd1, 10'd1023, 1'b1, 13'd4095);
    offer_fields(4'd1, 10'd1023, 1'b1, 13'd0);
    offer_fields(4'd1, 10'd1023, 1'b1, 13'd0);
    offer_fields(4'd1, 10'd1023, 1'b1, 13'h1000);
    offer_fields(4'd1, 10'd1, 1'b1, bts_pkg::CODE_W'(-4095));
    offer_fields(4'd1, 10'd1, 1'b1, 13'd1);
    for (int k = 1; k <= bts_pkg::PASS_SLOTS + 1; k++) begin
      offer_fields(bts_pkg::BUS_W'(bts_pkg::BUS_COUNT), bts_pkg::ADDR_W'(k), 1'b1, 13'd1);
    end
    offer_fields(bts_pkg::BUS_W'(bts_pkg::BUS_COUNT), 10'd5, 1'b1, 13'd4095);
    offer_fields(bts_pkg::BUS_W'(bts_pkg::BUS_COUNT),
                 bts_pkg::ADDR_W'(bts_pkg::PASS_SLOTS + 1), 1'b1, bts_pkg::CODE_W'(-1));
    drain();

    offer_random(400, 10);
    drain();
    offer_random(400, 10);
    drain();

    cfg_write(bts_pkg::REG_MONITOR_ENABLE, 32'hFFFF_FFFE);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    offer_random(100, 30);
    drain();

    cfg_write(bts_pkg::REG_MONITOR_ENABLE, 32'h0000_0001);
    for (int k = 0; k < bts_pkg::FAIL_SLOTS + 20; k++) begin
      offer_fields(4'd2, bts_pkg::ADDR_W'(900 + k), 1'b1, fail_pool[k % 8]);
    end
    for (int k = 0; k < 10; k++) begin
      offer_fields(4'd2, bts_pkg::ADDR_W'(900 + k), 1'b1, fail_pool[k % 8]);
    end
    offer_fields(4'd2, 10'd899, 1'b1, 13'd0);
    drain();

    draw_pools();
    src_max_gap  = 0;
    sink_max_gap = 0;
    offer_random(150, 10);
    drain();
    src_max_gap  = 12;
    sink_max_gap = 12;
    offer_random(450, 10);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
